[rtl/q2h_pkg.sv]
package q2h_pkg;

  // Field widths of the request and result channels.
  localparam int QUAT_WIDTH  = 16;
  localparam int ANGLE_WIDTH = 16;

  // Fixed-point formats and widths, most derived from the component width.
  localparam int FRAC      = QUAT_WIDTH - 1;
  localparam int PROD_W    = 2 * QUAT_WIDTH;
  localparam int TEST_W    = PROD_W + 1;
  localparam int VEC_W     = 31;
  localparam int MAG_W     = VEC_W - 1;
  localparam int ROT_W     = VEC_W + 3;
  localparam int ACC_W     = 32;
  localparam int THR_W     = 15;
  localparam int THR_SHIFT = 2 * FRAC - THR_W;
  localparam int ROUND_SH  = ACC_W - ANGLE_WIDTH;

  localparam logic signed [VEC_W-1:0] DEN_ONE   = VEC_W'(64'sd1 <<< (2 * FRAC - 3));
  localparam logic [ACC_W-1:0]        ANG_HALF  = ACC_W'(64'd1 << (ACC_W - 1));
  localparam logic [ACC_W-1:0]        ANG_ROUND = ACC_W'(64'd1 << (ROUND_SH - 1));
  localparam logic [THR_W-1:0]        THR_RESET = 15'd16351;

  localparam logic [1:0] REGION_NORMAL = 2'd0;
  localparam logic [1:0] REGION_NORTH  = 2'd1;
  localparam logic [1:0] REGION_SOUTH  = 2'd2;

  typedef struct packed {
    logic signed [QUAT_WIDTH-1:0] quat_x;
    logic signed [QUAT_WIDTH-1:0] quat_y;
    logic signed [QUAT_WIDTH-1:0] quat_z;
    logic signed [QUAT_WIDTH-1:0] quat_w;
  } q2h_in_t;

  typedef struct packed {
    logic signed [ANGLE_WIDTH-1:0] heading_angle;
    logic [1:0]                    pole_region;
  } q2h_out_t;

  // atan2 operands before normalization, with the OR of their magnitudes.
  typedef struct packed {
    logic signed [VEC_W-1:0] a;
    logic signed [VEC_W-1:0] b;
    logic [MAG_W-1:0]        mag;
    logic [1:0]              region;
  } q2h_vec_t;

  // CORDIC working vector and angle accumulator.
  typedef struct packed {
    logic signed [ROT_W-1:0] x;
    logic signed [ROT_W-1:0] y;
    logic [ACC_W-1:0]        ang;
    logic                    zero;
    logic [1:0]              region;
  } q2h_rot_t;

  // atan(2^-i) as a binary angle, a full turn being 2^32.
  function automatic logic [ACC_W-1:0] atan_tab(logic [4:0] idx);
    logic [ACC_W-1:0] v;
    unique case (idx)
      5'd0:    v = 32'h20000000;
      5'd1:    v = 32'h12E4051E;
      5'd2:    v = 32'h09FB385B;
      5'd3:    v = 32'h051111D4;
      5'd4:    v = 32'h028B0D43;
      5'd5:    v = 32'h0145D7E1;
      5'd6:    v = 32'h00A2F61E;
      5'd7:    v = 32'h00517C55;
      5'd8:    v = 32'h0028BE53;
      5'd9:    v = 32'h00145F2F;
      5'd10:   v = 32'h000A2F98;
      5'd11:   v = 32'h000517CC;
      5'd12:   v = 32'h00028BE6;
      5'd13:   v = 32'h000145F3;
      5'd14:   v = 32'h0000A2FA;
      5'd15:   v = 32'h0000517D;
      5'd16:   v = 32'h000028BE;
      5'd17:   v = 32'h0000145F;
      5'd18:   v = 32'h00000A30;
      5'd19:   v = 32'h00000518;
      5'd20:   v = 32'h0000028C;
      5'd21:   v = 32'h00000146;
      5'd22:   v = 32'h000000A3;
      5'd23:   v = 32'h00000051;
      5'd24:   v = 32'h00000029;
      5'd25:   v = 32'h00000014;
      5'd26:   v = 32'h0000000A;
      5'd27:   v = 32'h00000005;
      5'd28:   v = 32'h00000003;
      5'd29:   v = 32'h00000001;
      5'd30:   v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

[rtl/q2h_front.sv]
module q2h_front
  import q2h_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [THR_W-1:0] pole_thr,
  input  logic             in_vld,
  output logic             in_rdy,
  input  q2h_in_t          in_data,
  output logic             out_vld,
  input  logic             out_rdy,
  output q2h_vec_t         out_data
);

  localparam int NST = 4;

  logic [NST-1:0] vld_r;
  logic [NST:0]   en;

  assign en[NST] = out_rdy;
  for (genvar k = 0; k < NST; k++) begin : g_en
    assign en[k] = ~vld_r[k] | en[k+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) vld_r[0] <= in_vld;
      for (int i = 1; i < NST; i++) begin
        if (en[i]) vld_r[i] <= vld_r[i-1];
      end
    end
  end

  // Stage 1: the six component products.
  logic signed [PROD_W-1:0]     xy_r, zw_r, yw_r, xz_r, yy_r, zz_r;
  logic signed [QUAT_WIDTH-1:0] qx1_r, qw1_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      xy_r  <= in_data.quat_x * in_data.quat_y;
      zw_r  <= in_data.quat_z * in_data.quat_w;
      yw_r  <= in_data.quat_y * in_data.quat_w;
      xz_r  <= in_data.quat_x * in_data.quat_z;
      yy_r  <= in_data.quat_y * in_data.quat_y;
      zz_r  <= in_data.quat_z * in_data.quat_z;
      qx1_r <= in_data.quat_x;
      qw1_r <= in_data.quat_w;
    end
  end

  // Stage 2: pole test value and the atan2 operands of the normal case, both scaled by 1/8.
  logic signed [TEST_W-1:0]     test_r, test_nxt;
  logic signed [VEC_W-1:0]      num_r, num_nxt, den_r, den_nxt;
  logic signed [QUAT_WIDTH-1:0] qx2_r, qw2_r;

  always_comb begin
    test_nxt = TEST_W'(xy_r) + TEST_W'(zw_r);
    num_nxt  = VEC_W'(yw_r >>> 2) - VEC_W'(xz_r >>> 2);
    den_nxt  = DEN_ONE - VEC_W'(yy_r >>> 2) - VEC_W'(zz_r >>> 2);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      test_r <= test_nxt;
      num_r  <= num_nxt;
      den_r  <= den_nxt;
      qx2_r  <= qx1_r;
      qw2_r  <= qw1_r;
    end
  end

  // Stage 3: region decision and operand selection.
  logic signed [TEST_W-1:0] thr_s;
  logic                     north, south;
  logic signed [VEC_W-1:0]  a_r, b_r, a_nxt, b_nxt;
  logic [1:0]               region_r, region_nxt;

  assign thr_s = TEST_W'({1'b0, pole_thr, {THR_SHIFT{1'b0}}});
  assign north = test_r > thr_s;
  assign south = test_r < -thr_s;

  always_comb begin
    if (north || south) begin
      a_nxt      = VEC_W'(qx2_r);
      b_nxt      = VEC_W'(qw2_r);
      region_nxt = north ? REGION_NORTH : REGION_SOUTH;
    end else begin
      a_nxt      = num_r;
      b_nxt      = den_r;
      region_nxt = REGION_NORMAL;
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      a_r      <= a_nxt;
      b_r      <= b_nxt;
      region_r <= region_nxt;
    end
  end

  // Stage 4: magnitudes, merged by OR for the leading-one search.
  logic [VEC_W-1:0] mag_a, mag_b;
  q2h_vec_t         vec_r;

  assign mag_a = a_r[VEC_W-1] ? VEC_W'(-a_r) : VEC_W'(a_r);
  assign mag_b = b_r[VEC_W-1] ? VEC_W'(-b_r) : VEC_W'(b_r);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      vec_r.a      <= a_r;
      vec_r.b      <= b_r;
      vec_r.mag    <= mag_a[MAG_W-1:0] | mag_b[MAG_W-1:0];
      vec_r.region <= region_r;
    end
  end

  assign in_rdy   = en[0];
  assign out_vld  = vld_r[NST-1];
  assign out_data = vec_r;

endmodule

[rtl/q2h_norm.sv]
module q2h_norm
  import q2h_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_vld,
  output logic     in_rdy,
  input  q2h_vec_t in_data,
  output logic     out_vld,
  input  logic     out_rdy,
  output q2h_rot_t out_data
);

  localparam int NST = 3;

  logic [NST-1:0] vld_r;
  logic [NST:0]   en;

  assign en[NST] = out_rdy;
  for (genvar k = 0; k < NST; k++) begin : g_en
    assign en[k] = ~vld_r[k] | en[k+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) vld_r[0] <= in_vld;
      for (int i = 1; i < NST; i++) begin
        if (en[i]) vld_r[i] <= vld_r[i-1];
      end
    end
  end

  // Shifts both operands left by sh when the top sh bits of the magnitude are clear.
  function automatic q2h_vec_t norm_step(q2h_vec_t v, int unsigned sh);
    q2h_vec_t r;
    r = v;
    if ((v.mag >> (MAG_W - sh)) == '0) begin
      r.a   = v.a <<< sh;
      r.b   = v.b <<< sh;
      r.mag = v.mag << sh;
    end
    return r;
  endfunction

  q2h_vec_t n1_r, n1_nxt, n2_r, n2_nxt;
  q2h_rot_t rot_r, rot_nxt;

  assign n1_nxt = norm_step(norm_step(in_data, 16), 8);
  assign n2_nxt = norm_step(norm_step(norm_step(n1_r, 4), 2), 1);

  // Start vector: x from the second operand; a negative x is folded over by half a turn.
  always_comb begin
    rot_nxt.x      = ROT_W'(n2_r.b);
    rot_nxt.y      = ROT_W'(n2_r.a);
    rot_nxt.ang    = '0;
    rot_nxt.zero   = ~n2_r.mag[MAG_W-1];
    rot_nxt.region = n2_r.region;
    if (n2_r.b[VEC_W-1]) begin
      rot_nxt.x   = -ROT_W'(n2_r.b);
      rot_nxt.y   = -ROT_W'(n2_r.a);
      rot_nxt.ang = ANG_HALF;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) n1_r  <= n1_nxt;
    if (en[1]) n2_r  <= n2_nxt;
    if (en[2]) rot_r <= rot_nxt;
  end

  assign in_rdy   = en[0];
  assign out_vld  = vld_r[NST-1];
  assign out_data = rot_r;

endmodule

[rtl/q2h_cordic.sv]
module q2h_cordic
  import q2h_pkg::*;
#(
  parameter int STEPS = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_vld,
  output logic     in_rdy,
  input  q2h_rot_t in_data,
  output logic     out_vld,
  input  logic     out_rdy,
  output q2h_rot_t out_data
);

  logic [STEPS-1:0] vld_r;
  logic [STEPS:0]   en;

  assign en[STEPS] = out_rdy;
  for (genvar k = 0; k < STEPS; k++) begin : g_en
    assign en[k] = ~vld_r[k] | en[k+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) vld_r[0] <= in_vld;
      for (int i = 1; i < STEPS; i++) begin
        if (en[i]) vld_r[i] <= vld_r[i-1];
      end
    end
  end

  q2h_rot_t stg [STEPS+1];
  q2h_rot_t st_r [STEPS];
  q2h_rot_t st_nxt [STEPS];

  always_comb begin
    stg[0] = in_data;
    for (int i = 0; i < STEPS; i++) begin
      stg[i+1] = st_r[i];
    end
  end

  // One micro-rotation per stage, always driving y toward zero.
  always_comb begin
    for (int i = 0; i < STEPS; i++) begin
      st_nxt[i] = stg[i];
      if (!stg[i].y[ROT_W-1]) begin
        st_nxt[i].x   = stg[i].x + (stg[i].y >>> i);
        st_nxt[i].y   = stg[i].y - (stg[i].x >>> i);
        st_nxt[i].ang = stg[i].ang + atan_tab(5'(i));
      end else begin
        st_nxt[i].x   = stg[i].x - (stg[i].y >>> i);
        st_nxt[i].y   = stg[i].y + (stg[i].x >>> i);
        st_nxt[i].ang = stg[i].ang - atan_tab(5'(i));
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < STEPS; i++) begin
      if (en[i]) st_r[i] <= st_nxt[i];
    end
  end

  assign in_rdy   = en[0];
  assign out_vld  = vld_r[STEPS-1];
  assign out_data = st_r[STEPS-1];

endmodule

[rtl/q2h_finish.sv]
module q2h_finish
  import q2h_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_vld,
  output logic     in_rdy,
  input  q2h_rot_t in_data,
  output logic     out_vld,
  input  logic     out_rdy,
  output q2h_out_t out_data
);

  localparam int NST = 2;

  logic [NST-1:0] vld_r;
  logic [NST:0]   en;

  assign en[NST] = out_rdy;
  for (genvar k = 0; k < NST; k++) begin : g_en
    assign en[k] = ~vld_r[k] | en[k+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) vld_r[0] <= in_vld;
      if (en[1]) vld_r[1] <= vld_r[0];
    end
  end

  // Stage 1: a zero vector gives angle zero; pole branches double the angle, the south pole also negates it.
  logic [ACC_W-1:0] ang_r, ang_nxt, dbl;
  logic [1:0]       region_r;

  assign dbl = {in_data.ang[ACC_W-2:0], 1'b0};

  always_comb begin
    if (in_data.zero) begin
      ang_nxt = '0;
    end else begin
      case (in_data.region)
        REGION_NORTH: ang_nxt = dbl;
        REGION_SOUTH: ang_nxt = -dbl;
        default:      ang_nxt = in_data.ang;
      endcase
    end
  end

  // Stage 2: round to nearest, half up, wrapping around the circle.
  logic [ACC_W-1:0] rnd;
  q2h_out_t         out_r;

  assign rnd = ang_r + ANG_ROUND;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      ang_r    <= ang_nxt;
      region_r <= in_data.region;
    end
    if (en[1]) begin
      out_r.heading_angle <= rnd[ACC_W-1 -: ANGLE_WIDTH];
      out_r.pole_region   <= region_r;
    end
  end

  assign in_rdy   = en[0];
  assign out_vld  = vld_r[NST-1];
  assign out_data = out_r;

endmodule

[rtl/quaternion_to_heading_top.sv]
// Heading (yaw) of a unit quaternion given in Q1.15. Each request carries x, y, z
// and w; the result is the heading as a 16-bit binary angle (32768 is pi, wrapping)
// and a region code telling whether the normal formula or one of the two pole
// formulas was used. The pole test compares x*y + z*w against the programmable
// threshold (Q0.15, reset value 0.499); a test exactly at the threshold counts as
// normal. The block is a fully pipelined datapath: a new request is accepted every
// cycle while the output is not stalled. It has CORDIC_STEPS + 9 register
// stages: four for the products, the pole test and the operand magnitudes, three
// for normalization, one per CORDIC micro-rotation, and two for the pole
// adjustment and final rounding. The CORDIC stage count sets both the latency
// and the angle accuracy. Each stage holds its item when the next stage is
// stalled, so in_ready stays high while any bubble remains in the pipeline, even
// with a result waiting at the output. The threshold register is written through
// the cfg port, which is always ready; it must only be written while no request is
// in flight.
module quaternion_to_heading_top
  import q2h_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
) (
  input  logic             clk,
  input  logic             rst_n,

  input  logic             in_valid,
  output logic             in_ready,
  input  q2h_in_t          in_data,

  output logic             out_valid,
  input  logic             out_ready,
  output q2h_out_t         out_data,

  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [THR_W-1:0] cfg_pole_threshold
);

  // Pole threshold register. Writes are only expected while the pipeline is empty,
  // so the datapath reads it directly without any staging.
  logic [THR_W-1:0] pole_thr_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pole_thr_r <= THR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      pole_thr_r <= cfg_pole_threshold;
    end
  end

  // Inter-module handshakes: each downstream ready backs up through the stage chain.
  logic     front_vld, front_rdy;
  q2h_vec_t front_data;
  logic     norm_vld, norm_rdy;
  q2h_rot_t norm_data;
  logic     cordic_vld, cordic_rdy;
  q2h_rot_t cordic_data;

  // Products, pole test, operand selection and magnitudes.
  q2h_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .pole_thr (pole_thr_r),
    .in_vld   (in_valid),
    .in_rdy   (in_ready),
    .in_data  (in_data),
    .out_vld  (front_vld),
    .out_rdy  (front_rdy),
    .out_data (front_data)
  );

  // Leading-one normalization of the atan2 operands and the half-plane fold.
  q2h_norm u_norm (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (front_vld),
    .in_rdy   (front_rdy),
    .in_data  (front_data),
    .out_vld  (norm_vld),
    .out_rdy  (norm_rdy),
    .out_data (norm_data)
  );

  // Vectoring CORDIC, one micro-rotation per stage.
  q2h_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (norm_vld),
    .in_rdy   (norm_rdy),
    .in_data  (norm_data),
    .out_vld  (cordic_vld),
    .out_rdy  (cordic_rdy),
    .out_data (cordic_data)
  );

  // Pole adjustment, rounding to the output width, and the output register.
  q2h_finish u_finish (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (cordic_vld),
    .in_rdy   (cordic_rdy),
    .in_data  (cordic_data),
    .out_vld  (out_valid),
    .out_rdy  (out_ready),
    .out_data (out_data)
  );

  // A ready consumer must never hold back the request side: every stage can move.
  a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("in_ready low while out_ready is high");

  // A delivered result carries one of the three region codes.
  a_region_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.pole_region == REGION_NORMAL ||
                   out_data.pole_region == REGION_NORTH ||
                   out_data.pole_region == REGION_SOUTH))
    else $error("invalid pole region code on the result");

  // Reset empties the whole pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule
